// File: rtl/core/mbvs_pkg.sv
`default_nettype none

package mbvs_pkg;

   // item kinds carried by the request channel
   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   localparam int unsigned WADDR_W = 13;
   localparam int unsigned DATA_W  = 8;
   localparam int unsigned COL_W   = 9;
   localparam int unsigned LINE_W  = 8;

   localparam logic [LINE_W-1:0] LINE_FIRST = 8'h20;
   localparam logic [LINE_W-1:0] LINE_LAST  = 8'hFF;
   localparam logic [LINE_W-1:0] ROW_LAST   = 8'd223;
   localparam logic [COL_W-1:0]  COL_LAST   = 9'd259;
   localparam logic [2:0]        LOAD_PHASE = 3'd4;

   // decoupling queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      cmd_type             cmd;
      logic [WADDR_W-1:0]  addr;
      logic [DATA_W-1:0]   data;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

`default_nettype wire

// File: rtl/core/mbvs_ram.sv
`default_nettype none

module mbvs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/mbvs_front.sv
`default_nettype none

module mbvs_front
   import mbvs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               hold,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_cmd,
   input  wire logic [WADDR_W-1:0] req_write_address,
   input  wire logic [DATA_W-1:0]  req_write_data,
   output queue_head_type          head,
   input  wire logic               pop
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop_ok;
   item_type          new_item;

   // classify the incoming word
   always_comb begin
      new_item.cmd  = (req_cmd == 1'b1) ? CMD_TICK : CMD_WRITE;
      new_item.addr = req_write_address;
      new_item.data = req_write_data;
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH)) && !hold;
   assign push      = req_valid && req_ready;
   assign pop_ok    = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: rtl/core/mbvs_back.sv
`default_nettype none

module mbvs_back
   import mbvs_pkg::*;
#(
   parameter int unsigned VRAM_DEPTH = 8192
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  queue_head_type         head,
   output logic                   pop,
   output logic                   clr_busy,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_pixel,
   output logic      [COL_W-1:0]  rsp_column,
   output logic      [LINE_W-1:0] rsp_row,
   output logic                   rsp_line_end,
   output logic                   rsp_frame_end
);

   localparam int unsigned ADDR_W = $clog2(VRAM_DEPTH);

   logic                clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic [DATA_W-1:0]   shift_ff, shift_in;
   logic                load_pend_ff, load_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_pixel_ff;
   logic [COL_W-1:0]    rsp_column_ff;
   logic [LINE_W-1:0]   rsp_row_ff;
   logic                rsp_line_end_ff;
   logic                rsp_frame_end_ff;

   logic                out_free;
   logic                fire_write;
   logic                fire_tick;
   logic                last_col;
   logic [COL_W-1:0]    next_col;
   logic                load;
   logic [DATA_W-1:0]   shift_now;
   logic [DATA_W-1:0]   rd_data;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_wa;
   logic [DATA_W-1:0]   ram_wd;
   logic [WADDR_W-1:0]  fetch_addr;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pop        = head.valid && !clr_busy_ff
                       && ((head.item.cmd == CMD_WRITE) || out_free);
   assign fire_write = pop && (head.item.cmd == CMD_WRITE);
   assign fire_tick  = pop && (head.item.cmd == CMD_TICK);

   assign last_col   = (col_ff >= COL_LAST);
   assign next_col   = col_ff + 1'b1;
   assign load       = !last_col && !next_col[COL_W-1] && (next_col[2:0] == LOAD_PHASE);
   assign fetch_addr = {line_ff, next_col[COL_W-2:3]};

   // a fetched byte is taken from the ram output in the cycle after its read
   assign shift_now  = load_pend_ff ? rd_data : shift_ff;

   always_comb begin
      ram_we = fire_write;
      ram_wa = head.item.addr[ADDR_W-1:0];
      ram_wd = head.item.data;
      if (clr_busy_ff) begin
         ram_we = 1'b1;
         ram_wa = clr_addr_ff;
         ram_wd = '0;
      end
   end

   mbvs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (VRAM_DEPTH)
   ) u_vram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (fire_tick && load),
      .rd_addr (fetch_addr[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      clr_busy_in  = clr_busy_ff;
      clr_addr_in  = clr_addr_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      shift_in     = shift_now;
      load_pend_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(VRAM_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      if (fire_tick) begin
         rsp_valid_in = 1'b1;
         shift_in     = shift_now >> 1;
         if (last_col) begin
            col_in   = '0;
            shift_in = '0;
            line_in  = (line_ff == LINE_LAST) ? LINE_FIRST : line_ff + 1'b1;
         end else begin
            col_in       = next_col;
            load_pend_in = load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         col_ff       <= '0;
         line_ff      <= LINE_FIRST;
         shift_ff     <= '0;
         load_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         shift_ff     <= shift_in;
         load_pend_ff <= load_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_tick) begin
         rsp_pixel_ff     <= shift_now[0];
         rsp_column_ff    <= col_ff;
         rsp_row_ff       <= line_ff - LINE_FIRST;
         rsp_line_end_ff  <= last_col;
         rsp_frame_end_ff <= last_col && (line_ff == LINE_LAST);
      end
   end

   assign clr_busy      = clr_busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel     = rsp_pixel_ff;
   assign rsp_column    = rsp_column_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_line_end  = rsp_line_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

`default_nettype wire

// File: rtl/core/mono_bitmap_video_scanout.sv
// pixel path: a tick word passes the queue entry, then the output reg, before its pixel
//   shows on rsp_; the output reg holds it while rsp_ready is low
// throughput: one word per cycle, write or tick, while no tick waits on rsp_ready; the back
//   retires one queue head per cycle and the byte fetch overlaps the pixel ticks, so it
//   never waits on the ram; reset: synchronous; afterwards the video ram is zeroed one byte
//   per cycle, during which req_ready stays low
`default_nettype none

module mono_bitmap_video_scanout
   import mbvs_pkg::*;
#(
   parameter int unsigned VRAM_DEPTH = 8192
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_cmd,
   input  wire logic [WADDR_W-1:0] req_write_address,
   input  wire logic [DATA_W-1:0]  req_write_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_pixel,
   output logic      [COL_W-1:0]   rsp_column,
   output logic      [LINE_W-1:0]  rsp_row,
   output logic                    rsp_line_end,
   output logic                    rsp_frame_end
);

   // front/back split: the front takes and decodes words into a short queue,
   // the back owns the raster counters, the pixel shifter and the video ram
   queue_head_type head;
   logic           pop;
   logic           clr_busy;

   mbvs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .hold              (clr_busy),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_write_address (req_write_address),
      .req_write_data    (req_write_data),
      .head              (head),
      .pop               (pop)
   );

   // the back issues the byte fetch on the tick before the first pixel of a byte,
   // and folds the ram read data into the shifter the following cycle
   mbvs_back #(
      .VRAM_DEPTH (VRAM_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .clr_busy      (clr_busy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel     (rsp_pixel),
      .rsp_column    (rsp_column),
      .rsp_row       (rsp_row),
      .rsp_line_end  (rsp_line_end),
      .rsp_frame_end (rsp_frame_end)
   );

   // nothing leaves while the ram is still being zeroed
   a_no_rsp_during_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !rsp_valid && !pop)
      else $error("result word during ram clear");

   // line end only on the last column
   a_line_end_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_end == (rsp_column == COL_LAST)))
      else $error("line end does not match column");

   // frame end only at the end of the last visible row
   a_frame_end_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> (rsp_line_end && (rsp_row == ROW_LAST)))
      else $error("frame end off the last row");

   // blank lead-in: the first four columns of a line are always black
   a_blank_lead: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_column < 9'd4)) |-> !rsp_pixel)
      else $error("lit pixel in blank lead-in");

endmodule

`default_nettype wire

// File: bench/tb_mono_bitmap_video_scanout.sv
module tb_mono_bitmap_video_scanout;
   import mbvs_pkg::*;

   localparam int unsigned VRAM_BYTES    = 8192;
   localparam int unsigned VISIBLE_COLS  = 256;
   localparam int unsigned RESET_CYCLES  = 12;
   localparam int unsigned PHASE_WORDS   = 650;
   // clear pass + three idling phases of random words, then many times over
   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned REPORT_MAX    = 10;

   // one expected pixel word on the rsp_ channel
   typedef struct packed {
      logic              pixel;
      logic [COL_W-1:0]  column;
      logic [LINE_W-1:0] row;
      logic              line_end;
      logic              frame_end;
   } scan_pixel_type;

   // clock, reset and dut ports; the driven ones are known from time zero
   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_ready;
   logic                req_cmd           = 1'b0;
   logic [WADDR_W-1:0]  req_write_address = '0;
   logic [DATA_W-1:0]   req_write_data    = '0;
   logic                rsp_valid;
   logic                rsp_ready         = 1'b0;
   logic                rsp_pixel;
   logic [COL_W-1:0]    rsp_column;
   logic [LINE_W-1:0]   rsp_row;
   logic                rsp_line_end;
   logic                rsp_frame_end;

   // words waiting for the driver, pixels waiting for the dut
   item_type            pending_words[$];
   scan_pixel_type      expected_pixels[$];

   // shadow of the scanout state, advanced on every accepted word
   logic [DATA_W-1:0]   shadow_vram [VRAM_BYTES];
   logic [DATA_W-1:0]   shadow_shifter;
   logic [COL_W-1:0]    shadow_col;
   logic [LINE_W-1:0]   shadow_line;

   // raster position as seen by the stimulus generator, so writes can aim at lines
   // that are about to be scanned
   logic [COL_W-1:0]    plan_col  = '0;
   logic [LINE_W-1:0]   plan_line = LINE_FIRST;

   int unsigned         snd_idle_pct = 0;
   int unsigned         rcv_idle_pct = 0;
   int unsigned         cycle_count  = 0;
   int unsigned         miss_count   = 0;
   int unsigned         writes_taken = 0;
   int unsigned         ticks_taken  = 0;
   int unsigned         pixels_seen  = 0;
   int unsigned         white_seen   = 0;
   int unsigned         frames_seen  = 0;

   mono_bitmap_video_scanout #(
      .VRAM_DEPTH (VRAM_BYTES)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_write_address (req_write_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel         (rsp_pixel),
      .rsp_column        (rsp_column),
      .rsp_row           (rsp_row),
      .rsp_line_end      (rsp_line_end),
      .rsp_frame_end     (rsp_frame_end)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // scanout predictor
   // ------------------------------------------------------------------

   function automatic logic [LINE_W-1:0] line_after(logic [LINE_W-1:0] l);
      return (l == LINE_LAST) ? LINE_FIRST : l + 1'b1;
   endfunction

   function automatic void scan_reset();
      foreach (shadow_vram[i]) shadow_vram[i] = '0;
      shadow_shifter = '0;
      shadow_col     = '0;
      shadow_line    = LINE_FIRST;
   endfunction

   // apply one accepted word; a tick queues the pixel it must produce
   function automatic void scan_accept(item_type w);
      scan_pixel_type   p;
      logic [COL_W-1:0] nxt;
      logic             last_col;
      if (w.cmd == CMD_WRITE) begin
         // 13-bit address covers the whole ram, so no wrap is needed
         shadow_vram[w.addr] = w.data;
         writes_taken++;
      end else begin
         last_col    = (shadow_col >= COL_LAST);
         p.pixel     = shadow_shifter[0];
         p.column    = shadow_col;
         p.row       = shadow_line - LINE_FIRST;
         p.line_end  = last_col;
         p.frame_end = last_col && (shadow_line == LINE_LAST);
         expected_pixels.push_back(p);
         ticks_taken++;
         shadow_shifter = shadow_shifter >> 1;
         if (last_col) begin
            // flush columns leave the shifter empty for the next line
            shadow_col     = '0;
            shadow_shifter = '0;
            shadow_line    = line_after(shadow_line);
         end else begin
            nxt        = shadow_col + 1'b1;
            shadow_col = nxt;
            // byte load half way into each 8-pixel cell, visible area only
            if (nxt < VISIBLE_COLS && nxt[2:0] == LOAD_PHASE)
               shadow_shifter = shadow_vram[{shadow_line, nxt[7:3]}];
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // stimulus generation
   // ------------------------------------------------------------------

   function automatic void plan_write(logic [WADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      item_type w;
      w.cmd  = CMD_WRITE;
      w.addr = addr;
      w.data = data;
      pending_words.push_back(w);
   endfunction

   // address and data of a tick are don't-care, so they carry noise
   function automatic void plan_tick();
      item_type w;
      w.cmd  = CMD_TICK;
      w.addr = WADDR_W'($urandom);
      w.data = DATA_W'($urandom);
      pending_words.push_back(w);
      if (plan_col >= COL_LAST) begin
         plan_col  = '0;
         plan_line = line_after(plan_line);
      end else begin
         plan_col = plan_col + 1'b1;
      end
   endfunction

   // mostly ticks; writes mostly aimed at the line in flight or the next one, some at random addresses
   function automatic void fill_random(int unsigned count);
      int unsigned       pick;
      logic [LINE_W-1:0] tl;
      logic [4:0]        slot;
      for (int unsigned n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            plan_tick();
         end else if (pick < 86) begin
            tl = ($urandom_range(1) == 0) ? plan_line : line_after(plan_line);
            plan_write({tl, 5'($urandom)}, DATA_W'($urandom));
         end else if (pick < 94) begin
            // the byte right after the current one, likely loaded within a few ticks
            slot = plan_col[7:3] + 1'b1;
            plan_write({plan_line, slot}, DATA_W'($urandom));
         end else begin
            plan_write(WADDR_W'($urandom), DATA_W'($urandom));
         end
      end
   endfunction

   // sender holds off until the dut has returned every pixel
   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(negedge clock);
   endtask

   task automatic note_miss(string what);
      if (miss_count < REPORT_MAX)
         $display("mismatch: %s", what);
      miss_count++;
   endtask

   // ------------------------------------------------------------------
   // request driver: holds a word until accepted, idles at random between words
   // ------------------------------------------------------------------

   always @(posedge clock) begin : driver
      item_type w;
      if (reset) begin
         req_valid <= 1'b0;
         scan_reset();
      end else begin
         // the word on the port right now is the one accepted at this edge
         if (req_valid && req_ready) begin
            w.cmd  = cmd_type'(req_cmd);
            w.addr = req_write_address;
            w.data = req_write_data;
            scan_accept(w);
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
               w = pending_words.pop_front();
               req_valid         <= 1'b1;
               req_cmd           <= w.cmd;
               req_write_address <= w.addr;
               req_write_data    <= w.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // ------------------------------------------------------------------
   // pixel monitor: every accepted word against the oldest expectation
   // ------------------------------------------------------------------

   always @(posedge clock) begin : monitor
      scan_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            note_miss($sformatf("unexpected pixel word: pix %0b col %0d row %0d le %0b fe %0b",
                                rsp_pixel, rsp_column, rsp_row, rsp_line_end, rsp_frame_end));
         end else begin
            want = expected_pixels.pop_front();
            pixels_seen++;
            if (rsp_pixel !== want.pixel || rsp_column !== want.column ||
                rsp_row !== want.row || rsp_line_end !== want.line_end ||
                rsp_frame_end !== want.frame_end) begin
               note_miss($sformatf({"expected pix %0b col %0d row %0d le %0b fe %0b, ",
                                    "got pix %0b col %0d row %0d le %0b fe %0b"},
                                   want.pixel, want.column, want.row, want.line_end,
                                   want.frame_end, rsp_pixel, rsp_column, rsp_row,
                                   rsp_line_end, rsp_frame_end));
            end else begin
               if (want.pixel)
                  white_seen++;
               if (want.frame_end)
                  frames_seen++;
            end
         end
      end
   end

   // watchdog, also covers pixels that never come back
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels still owed",
                  cycle_count, expected_pixels.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles lightly, receiver heavily
      snd_idle_pct = 21;
      rcv_idle_pct = 46;

      // directed: first cells of line 0x20, the four blank lead-in pixels, then the load
      plan_write(13'h0400, 8'hA5);
      plan_write(13'h0401, 8'h81);
      plan_write(13'h041F, 8'hFF);
      repeat (6) plan_tick();
      // cell 0 is already in the shifter, so this overwrite must not show
      plan_write(13'h0400, 8'h00);
      // cell 1 loads at column 12, so this one must show
      plan_write(13'h0401, 8'h7E);
      repeat (8) plan_tick();
      // address extremes; the top byte is read out on the last line of the frame
      plan_write(13'h1FFF, 8'hFF);
      plan_write(13'h0000, 8'hFF);
      plan_write(13'h0000, 8'h00);

      fill_random(PHASE_WORDS);
      wait_drained();

      // phase two: roles swapped
      snd_idle_pct = 46;
      rcv_idle_pct = 21;
      fill_random(PHASE_WORDS);
      wait_drained();

      // phase three: full rate
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      fill_random(PHASE_WORDS);
      wait_drained();

      // let any stray pixel word surface before judging
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d writes and %0d ticks, %0d pixels checked (%0d white), %0d frame wraps",
               writes_taken, ticks_taken, pixels_seen, white_seen, frames_seen);
      $display("idle mix 21/46, 46/21 and none, with a full drain between phases; %0d mismatches",
               miss_count);
      if (miss_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: mono_bitmap_video_scanout.f
rtl/core/mbvs_pkg.sv
rtl/core/mbvs_ram.sv
rtl/core/mbvs_front.sv
rtl/core/mbvs_back.sv
rtl/core/mono_bitmap_video_scanout.sv
bench/tb_mono_bitmap_video_scanout.sv
